FILE: rtl/blca_pkg.sv
// shared types, constants and helpers for the binary lifting common ancestor block
package blca_pkg;

  localparam int NODE_W      = 10;
  localparam int MAX_NODES   = 1 << NODE_W;
  localparam int LIFT_LEVELS = 10;
  localparam int DEPTH_W     = NODE_W;
  localparam int LVL_W       = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
  localparam int ANC_DEPTH   = MAX_NODES * LIFT_LEVELS;
  localparam int ANC_AW      = $clog2(ANC_DEPTH);
  localparam int CMP_W       = ((DEPTH_W > LIFT_LEVELS) ? DEPTH_W : LIFT_LEVELS) + 1;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;
  typedef logic [LVL_W-1:0]   lvl_t;
  typedef logic [ANC_AW-1:0]  anc_addr_t;

  localparam lvl_t   LVL_LAST  = lvl_t'(LIFT_LEVELS - 1);
  localparam depth_t DEPTH_MAX = '1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic  valid;
    node_t node;
  } anc_t;

  localparam int ANC_W = $bits(anc_t);

  typedef struct packed {
    logic   we;
    node_t  waddr;
    depth_t wdata;
    node_t  raddr;
  } dep_req_t;

  typedef struct packed {
    logic      we;
    anc_addr_t waddr;
    anc_t      wdata;
    anc_addr_t raddr;
  } anc_req_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LD_DEP,
    S_LD_ROW0,
    S_LD_RD,
    S_LD_WR,
    S_LD_ROOT,
    S_Q_DA,
    S_Q_DB,
    S_Q_SW,
    S_A_RD,
    S_A_EV,
    S_A_DP,
    S_CMP,
    S_B_RP,
    S_B_RQ,
    S_B_EV,
    S_F_RD,
    S_F_EV
  } state_t;

  // row-major placement: one row of lift levels per node
  function automatic anc_addr_t anc_addr(input node_t n, input lvl_t l);
    return ANC_AW'(n) * ANC_AW'(LIFT_LEVELS) + ANC_AW'(l);
  endfunction

endpackage

FILE: rtl/blca_ram.sv
// generic single write port, single registered read port ram
module blca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/blca_ctrl.sv
// sequencer for node loads and common ancestor queries over the depth and ancestor rams
module blca_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              cmd,
  input  blca_pkg::node_t   node_a,
  input  blca_pkg::node_t   node_b,
  input  blca_pkg::node_t   parent_node,
  input  logic              has_parent,
  output blca_pkg::dep_req_t dep_req,
  input  blca_pkg::depth_t  dep_rdata,
  output blca_pkg::anc_req_t anc_req,
  input  blca_pkg::anc_t    anc_rdata,
  output logic              res_valid,
  output blca_pkg::node_t   res_node
);

  blca_pkg::state_t state_r, state_nxt;

  blca_pkg::node_t  a_r, a_nxt;
  blca_pkg::node_t  b_r, b_nxt;
  blca_pkg::node_t  par_r, par_nxt;
  blca_pkg::lvl_t   lvl_r, lvl_nxt;
  blca_pkg::anc_t   prev_r, prev_nxt;
  blca_pkg::anc_t   ep_r, ep_nxt;
  blca_pkg::depth_t dp_r, dp_nxt;
  blca_pkg::depth_t dq_r, dq_nxt;
  blca_pkg::node_t  res_r, res_nxt;
  logic             res_valid_r, res_valid_nxt;

  logic                         accept;
  logic                         lvl_last;
  logic                         lvl_zero;
  logic [blca_pkg::CMP_W-1:0]   diff_w;
  logic [blca_pkg::CMP_W-1:0]   step_w;
  logic                         can_lift;
  logic                         pair_lift;

  assign busy     = (state_r != blca_pkg::S_IDLE);
  assign accept   = start && !busy;
  assign lvl_last = (lvl_r == blca_pkg::LVL_LAST);
  assign lvl_zero = (lvl_r == '0);

  // deeper node stays in a, so the difference never goes negative
  assign diff_w    = blca_pkg::CMP_W'(dp_r - dq_r);
  assign step_w    = blca_pkg::CMP_W'(1) << lvl_r;
  assign can_lift  = (diff_w >= step_w) && anc_rdata.valid;
  assign pair_lift = ep_r.valid && anc_rdata.valid && (ep_r.node != anc_rdata.node);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blca_pkg::S_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    par_r  <= par_nxt;
    lvl_r  <= lvl_nxt;
    prev_r <= prev_nxt;
    ep_r   <= ep_nxt;
    dp_r   <= dp_nxt;
    dq_r   <= dq_nxt;
    res_r  <= res_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      blca_pkg::S_IDLE: begin
        if (accept) begin
          if (cmd == blca_pkg::CMD_QUERY) begin
            state_nxt = blca_pkg::S_Q_DA;
          end else if (has_parent) begin
            state_nxt = blca_pkg::S_LD_DEP;
          end else begin
            state_nxt = blca_pkg::S_LD_ROOT;
          end
        end
      end
      blca_pkg::S_LD_DEP:  state_nxt = blca_pkg::S_LD_ROW0;
      blca_pkg::S_LD_ROW0: begin
        state_nxt = (blca_pkg::LIFT_LEVELS == 1) ? blca_pkg::S_IDLE : blca_pkg::S_LD_RD;
      end
      blca_pkg::S_LD_RD: begin
        if (prev_r.valid) begin
          state_nxt = blca_pkg::S_LD_WR;
        end else if (lvl_last) begin
          state_nxt = blca_pkg::S_IDLE;
        end
      end
      blca_pkg::S_LD_WR: begin
        state_nxt = lvl_last ? blca_pkg::S_IDLE : blca_pkg::S_LD_RD;
      end
      blca_pkg::S_LD_ROOT: begin
        if (lvl_last) begin
          state_nxt = blca_pkg::S_IDLE;
        end
      end
      blca_pkg::S_Q_DA: state_nxt = blca_pkg::S_Q_DB;
      blca_pkg::S_Q_DB: state_nxt = blca_pkg::S_Q_SW;
      blca_pkg::S_Q_SW: state_nxt = blca_pkg::S_A_RD;
      blca_pkg::S_A_RD: state_nxt = blca_pkg::S_A_EV;
      blca_pkg::S_A_EV: begin
        if (can_lift) begin
          state_nxt = blca_pkg::S_A_DP;
        end else begin
          state_nxt = lvl_zero ? blca_pkg::S_CMP : blca_pkg::S_A_RD;
        end
      end
      blca_pkg::S_A_DP: begin
        if (dep_rdata < dq_r || lvl_zero) begin
          state_nxt = blca_pkg::S_CMP;
        end else begin
          state_nxt = blca_pkg::S_A_RD;
        end
      end
      blca_pkg::S_CMP: begin
        state_nxt = (a_r == b_r) ? blca_pkg::S_IDLE : blca_pkg::S_B_RP;
      end
      blca_pkg::S_B_RP: state_nxt = blca_pkg::S_B_RQ;
      blca_pkg::S_B_RQ: state_nxt = blca_pkg::S_B_EV;
      blca_pkg::S_B_EV: begin
        state_nxt = lvl_zero ? blca_pkg::S_F_RD : blca_pkg::S_B_RP;
      end
      blca_pkg::S_F_RD: state_nxt = blca_pkg::S_F_EV;
      blca_pkg::S_F_EV: state_nxt = blca_pkg::S_IDLE;
      default:          state_nxt = blca_pkg::S_IDLE;
    endcase
  end

  // memory requests and datapath
  always_comb begin
    a_nxt         = a_r;
    b_nxt         = b_r;
    par_nxt       = par_r;
    lvl_nxt       = lvl_r;
    prev_nxt      = prev_r;
    ep_nxt        = ep_r;
    dp_nxt        = dp_r;
    dq_nxt        = dq_r;
    res_nxt       = res_r;
    res_valid_nxt = 1'b0;
    dep_req       = '0;
    anc_req       = '0;
    unique case (state_r)
      blca_pkg::S_IDLE: begin
        if (accept) begin
          a_nxt   = node_a;
          b_nxt   = node_b;
          par_nxt = parent_node;
          lvl_nxt = '0;
        end
      end
      blca_pkg::S_LD_DEP: begin
        dep_req.raddr = par_r;
      end
      blca_pkg::S_LD_ROW0: begin
        // parent depth is read before the node's own depth is written
        dep_req.we          = 1'b1;
        dep_req.waddr       = a_r;
        dep_req.wdata       = (dep_rdata == blca_pkg::DEPTH_MAX) ? dep_rdata
                                                                 : dep_rdata + 1'b1;
        anc_req.we          = 1'b1;
        anc_req.waddr       = blca_pkg::anc_addr(a_r, '0);
        anc_req.wdata.valid = 1'b1;
        anc_req.wdata.node  = par_r;
        prev_nxt.valid      = 1'b1;
        prev_nxt.node       = par_r;
        lvl_nxt             = blca_pkg::lvl_t'(1);
      end
      blca_pkg::S_LD_RD: begin
        if (prev_r.valid) begin
          anc_req.raddr = blca_pkg::anc_addr(prev_r.node, lvl_r - 1'b1);
        end else begin
          anc_req.we    = 1'b1;
          anc_req.waddr = blca_pkg::anc_addr(a_r, lvl_r);
          prev_nxt      = '0;
          lvl_nxt       = lvl_r + 1'b1;
        end
      end
      blca_pkg::S_LD_WR: begin
        anc_req.we    = 1'b1;
        anc_req.waddr = blca_pkg::anc_addr(a_r, lvl_r);
        anc_req.wdata = anc_rdata;
        prev_nxt      = anc_rdata;
        lvl_nxt       = lvl_r + 1'b1;
      end
      blca_pkg::S_LD_ROOT: begin
        dep_req.we    = 1'b1;
        dep_req.waddr = a_r;
        anc_req.we    = 1'b1;
        anc_req.waddr = blca_pkg::anc_addr(a_r, lvl_r);
        lvl_nxt       = lvl_r + 1'b1;
      end
      blca_pkg::S_Q_DA: begin
        dep_req.raddr = a_r;
      end
      blca_pkg::S_Q_DB: begin
        dp_nxt        = dep_rdata;
        dep_req.raddr = b_r;
      end
      blca_pkg::S_Q_SW: begin
        lvl_nxt = blca_pkg::LVL_LAST;
        if (dp_r < dep_rdata) begin
          a_nxt  = b_r;
          b_nxt  = a_r;
          dp_nxt = dep_rdata;
          dq_nxt = dp_r;
        end else begin
          dq_nxt = dep_rdata;
        end
      end
      blca_pkg::S_A_RD: begin
        anc_req.raddr = blca_pkg::anc_addr(a_r, lvl_r);
      end
      blca_pkg::S_A_EV: begin
        if (can_lift) begin
          a_nxt         = anc_rdata.node;
          dep_req.raddr = anc_rdata.node;
        end else if (!lvl_zero) begin
          lvl_nxt = lvl_r - 1'b1;
        end
      end
      blca_pkg::S_A_DP: begin
        // depth is re-read after each lift since stored depths may saturate
        dp_nxt = dep_rdata;
        if (!(dep_rdata < dq_r) && !lvl_zero) begin
          lvl_nxt = lvl_r - 1'b1;
        end
      end
      blca_pkg::S_CMP: begin
        lvl_nxt = blca_pkg::LVL_LAST;
        if (a_r == b_r) begin
          res_nxt       = a_r;
          res_valid_nxt = 1'b1;
        end
      end
      blca_pkg::S_B_RP: begin
        anc_req.raddr = blca_pkg::anc_addr(a_r, lvl_r);
      end
      blca_pkg::S_B_RQ: begin
        ep_nxt        = anc_rdata;
        anc_req.raddr = blca_pkg::anc_addr(b_r, lvl_r);
      end
      blca_pkg::S_B_EV: begin
        if (pair_lift) begin
          a_nxt = ep_r.node;
          b_nxt = anc_rdata.node;
        end
        if (!lvl_zero) begin
          lvl_nxt = lvl_r - 1'b1;
        end
      end
      blca_pkg::S_F_RD: begin
        anc_req.raddr = blca_pkg::anc_addr(a_r, '0);
      end
      blca_pkg::S_F_EV: begin
        res_nxt       = anc_rdata.valid ? anc_rdata.node : '0;
        res_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign res_valid = res_valid_r;
  assign res_node  = res_r;

endmodule

FILE: rtl/binary_lifting_lca.sv
// top level: lowest common ancestor by binary lifting, depth and ancestor rams plus sequencer
// a load with a parent writes the node's depth and every lift level, a root load writes invalid ancestors
// a query is a serial walk over the ancestor ram, level by level
// one item at a time: busy is high while an item is in progress, a new item is taken only while busy is low
// a query result shows on out_valid for one cycle once busy falls, never held off
// synchronous active-low reset clears the sequencer only; ram contents are undefined until loaded
module binary_lifting_lca (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_cmd,
  input  logic [9:0]            in_node_a,
  input  logic [9:0]            in_node_b,
  input  logic [9:0]            in_parent_node,
  input  logic                  in_has_parent,
  output logic                  out_valid,
  output logic [9:0]            out_lca_node
);

  blca_pkg::dep_req_t dep_req;
  blca_pkg::anc_req_t anc_req;
  blca_pkg::depth_t   dep_rdata;
  logic [blca_pkg::ANC_W-1:0] anc_rdata_w;
  blca_pkg::node_t    res_node;

  blca_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .cmd         (in_cmd),
    .node_a      (blca_pkg::node_t'(in_node_a)),
    .node_b      (blca_pkg::node_t'(in_node_b)),
    .parent_node (blca_pkg::node_t'(in_parent_node)),
    .has_parent  (in_has_parent),
    .dep_req     (dep_req),
    .dep_rdata   (dep_rdata),
    .anc_req     (anc_req),
    .anc_rdata   (blca_pkg::anc_t'(anc_rdata_w)),
    .res_valid   (out_valid),
    .res_node    (res_node)
  );

  blca_ram #(
    .WIDTH (blca_pkg::DEPTH_W),
    .DEPTH (blca_pkg::MAX_NODES)
  ) u_depth_ram (
    .clk   (clk),
    .we    (dep_req.we),
    .waddr (dep_req.waddr),
    .wdata (dep_req.wdata),
    .raddr (dep_req.raddr),
    .rdata (dep_rdata)
  );

  blca_ram #(
    .WIDTH (blca_pkg::ANC_W),
    .DEPTH (blca_pkg::ANC_DEPTH)
  ) u_anc_ram (
    .clk   (clk),
    .we    (anc_req.we),
    .waddr (anc_req.waddr),
    .wdata (anc_req.wdata),
    .raddr (anc_req.raddr),
    .rdata (anc_rdata_w)
  );

  assign out_lca_node = 10'(res_node);

endmodule

FILE: rtl/blca_checker.sv
// port-level checks for the common ancestor block, bound to the top level
module blca_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_cmd,
  input logic       out_valid
);

  // an accepted item always occupies the block in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // results come from separate queries, so strobes never touch
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results in consecutive cycles");

  // a result ends a query that was still in progress
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result with no item in progress");

  // a load item gives no result
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_cmd) |=> !out_valid ##1 !out_valid)
    else $error("result shown after a load item");

endmodule

bind binary_lifting_lca blca_checker u_blca_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_cmd    (in_cmd),
  .out_valid (out_valid)
);
